### design/c6502_pkg.sv
// Package for the 6502 execute unit: operation codes, flag bits, payload types.
// No dependencies.
`timescale 1ns / 1ps
package c6502_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
    OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
    OP_BRK = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
    OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
    OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
    OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34,
    OP_PHA = 6'd35, OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
    OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
    OP_TAX = 6'd50, OP_TAY = 6'd51, OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54,
    OP_TYA = 6'd55, OP_ILL = 6'd56
  } op_t;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0] SP_RESET = 8'd253;

  typedef struct packed {
    logic [5:0]  operation;
    logic [7:0]  operand;
    logic [15:0] address;
    logic        on_accumulator;
  } in_item_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  flags_out;
    logic [7:0]  sp_out;
    logic [15:0] pc_out;
    logic [1:0]  extra_cycles;
  } out_item_t;

  // stack port request from the sequencer to the stack memory
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] addr;
    logic [7:0] wdata;
  } stk_req_t;

endpackage

### design/c6502_if.sv
// Handshake channel interfaces for the 6502 execute unit.
// Depends on c6502_pkg.
`timescale 1ns / 1ps
interface c6502_in_if;
  logic                valid;
  logic                ready;
  c6502_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c6502_out_if;
  logic                 valid;
  logic                 ready;
  c6502_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c6502_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/cpu_6502_instruction_execute.sv
// 6502 execute unit: one decoded instruction per request, register file and stack page.
// Binary arithmetic only. An instruction without stack traffic, or PHA/PHP, ends in the run
// state and the next may follow at once if the output register is free. JSR adds S_PUSH1, BRK
// S_PUSH1/S_PUSH2, PLA/PLP S_PULL1, RTS S_PULL1/S_PULL2 and RTI S_PULL1 to S_PULL3, set by the
// single port of the 256-byte stack memory, one byte per cycle plus its read latency. A one-entry
// output register holds the result; a new request enters in the cycle that a waiting result is
// taken. Depends on c6502_pkg, the channel interfaces, c6502_stack and c6502_exec.
`timescale 1ns / 1ps
module cpu_6502_instruction_execute (
  input  logic         clk,
  input  logic         rst_n,
  c6502_in_if.sink     in_ch,
  c6502_out_if.source  out_ch,
  c6502_cfg_if.sink    cfg_ch
);
  c6502_pkg::stk_req_t stk_req;
  logic [7:0]          stk_rdata;

  c6502_stack u_stack (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  c6502_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata),
    .res_valid (out_ch.valid),
    .res_data  (out_ch.data),
    .res_ready (out_ch.ready)
  );
endmodule

### design/c6502_stack.sv
// Stack page: 256 x 8 single-port synchronous memory with registered read data.
// Depends on c6502_pkg.
`timescale 1ns / 1ps
module c6502_stack (
  input  logic                clk,
  input  c6502_pkg::stk_req_t req,
  output logic [7:0]          rdata
);
  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

### design/c6502_exec.sv
// Execute sequencer: register file, ALU and stack sequencing for one instruction.
// Depends on c6502_pkg and the channel interfaces; drives c6502_stack.
`timescale 1ns / 1ps
module c6502_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  c6502_in_if.sink             in_ch,
  c6502_cfg_if.sink            cfg_ch,
  output c6502_pkg::stk_req_t  stk_req,
  input  logic [7:0]           stk_rdata,
  output logic                 res_valid,
  output c6502_pkg::out_item_t res_data,
  input  logic                 res_ready
);
  typedef enum logic [2:0] {S_RUN, S_PUSH1, S_PUSH2, S_PULL1, S_PULL2, S_PULL3} state_t;

  state_t      state_r;
  logic [7:0]  a_r, x_r, y_r, sp_r, p_r;
  logic [15:0] pc_r, irq_r;
  logic [5:0]  op_r;
  logic [7:0]  b1_r, b2_r;
  logic [7:0]  lo_r;
  logic        res_valid_r;
  c6502_pkg::out_item_t res_r;

  logic        slot_free, take;
  c6502_pkg::in_item_t it;
  logic [7:0]  a_nxt, x_nxt, y_nxt, sp_nxt, p_nxt, src, r, m;
  logic [15:0] pc_nxt, ret;
  logic        wr, cond, isbr, stack_op;
  logic [7:0]  wdata;
  logic [8:0]  sum;
  logic [7:0]  madd;
  logic [1:0]  extra;

  assign slot_free  = !res_valid_r || res_ready;
  assign in_ch.ready = (state_r == S_RUN) && slot_free;
  assign take       = in_ch.valid && in_ch.ready;
  assign it         = in_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign res_valid  = res_valid_r;
  assign res_data   = res_r;
  assign m          = it.operand;

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r; pc_nxt = pc_r;
    wr = 1'b0; wdata = 8'd0; extra = 2'd0; cond = 1'b0; isbr = 1'b0; stack_op = 1'b0;
    src = it.on_accumulator ? a_r : m;
    r = 8'd0; ret = 16'd0;
    madd = (it.operation == c6502_pkg::OP_SBC) ? ~m : m;
    sum = {1'b0, a_r} + {1'b0, madd} + {8'd0, p_r[c6502_pkg::FL_C]};
    case (c6502_pkg::op_t'(it.operation))
      c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
        a_nxt = sum[7:0];
        p_nxt[c6502_pkg::FL_C] = sum[8];
        p_nxt[c6502_pkg::FL_V] = ~(a_r[7] ^ madd[7]) & (a_r[7] ^ sum[7]);
        r = sum[7:0];
      end
      c6502_pkg::OP_AND: begin a_nxt = a_r & m; r = a_nxt; end
      c6502_pkg::OP_ORA: begin a_nxt = a_r | m; r = a_nxt; end
      c6502_pkg::OP_EOR: begin a_nxt = a_r ^ m; r = a_nxt; end
      c6502_pkg::OP_ASL, c6502_pkg::OP_ROL: begin
        r = {src[6:0], (it.operation == c6502_pkg::OP_ROL) & p_r[c6502_pkg::FL_C]};
        p_nxt[c6502_pkg::FL_C] = src[7];
      end
      c6502_pkg::OP_LSR, c6502_pkg::OP_ROR: begin
        r = {(it.operation == c6502_pkg::OP_ROR) & p_r[c6502_pkg::FL_C], src[7:1]};
        p_nxt[c6502_pkg::FL_C] = src[0];
      end
      c6502_pkg::OP_BCC: begin isbr = 1'b1; cond = !p_r[c6502_pkg::FL_C]; end
      c6502_pkg::OP_BCS: begin isbr = 1'b1; cond =  p_r[c6502_pkg::FL_C]; end
      c6502_pkg::OP_BEQ: begin isbr = 1'b1; cond =  p_r[c6502_pkg::FL_Z]; end
      c6502_pkg::OP_BNE: begin isbr = 1'b1; cond = !p_r[c6502_pkg::FL_Z]; end
      c6502_pkg::OP_BMI: begin isbr = 1'b1; cond =  p_r[c6502_pkg::FL_N]; end
      c6502_pkg::OP_BPL: begin isbr = 1'b1; cond = !p_r[c6502_pkg::FL_N]; end
      c6502_pkg::OP_BVC: begin isbr = 1'b1; cond = !p_r[c6502_pkg::FL_V]; end
      c6502_pkg::OP_BVS: begin isbr = 1'b1; cond =  p_r[c6502_pkg::FL_V]; end
      c6502_pkg::OP_BIT: begin
        p_nxt[c6502_pkg::FL_Z] = (a_r & m) == 8'd0;
        p_nxt[c6502_pkg::FL_N] = m[7];
        p_nxt[c6502_pkg::FL_V] = m[6];
      end
      c6502_pkg::OP_CLC: p_nxt[c6502_pkg::FL_C] = 1'b0;
      c6502_pkg::OP_CLD: p_nxt[c6502_pkg::FL_D] = 1'b0;
      c6502_pkg::OP_CLI: p_nxt[c6502_pkg::FL_I] = 1'b0;
      c6502_pkg::OP_CLV: p_nxt[c6502_pkg::FL_V] = 1'b0;
      c6502_pkg::OP_SEC: p_nxt[c6502_pkg::FL_C] = 1'b1;
      c6502_pkg::OP_SED: p_nxt[c6502_pkg::FL_D] = 1'b1;
      c6502_pkg::OP_SEI: p_nxt[c6502_pkg::FL_I] = 1'b1;
      c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
        src = (it.operation == c6502_pkg::OP_CMP) ? a_r :
              (it.operation == c6502_pkg::OP_CPX) ? x_r : y_r;
        r = src - m;
        p_nxt[c6502_pkg::FL_C] = src >= m;
      end
      c6502_pkg::OP_DEC: begin r = m - 8'd1; wr = 1'b1; wdata = r; end
      c6502_pkg::OP_INC: begin r = m + 8'd1; wr = 1'b1; wdata = r; end
      c6502_pkg::OP_DEX: begin x_nxt = x_r - 8'd1; r = x_nxt; end
      c6502_pkg::OP_DEY: begin y_nxt = y_r - 8'd1; r = y_nxt; end
      c6502_pkg::OP_INX: begin x_nxt = x_r + 8'd1; r = x_nxt; end
      c6502_pkg::OP_INY: begin y_nxt = y_r + 8'd1; r = y_nxt; end
      c6502_pkg::OP_JMP: pc_nxt = it.address;
      c6502_pkg::OP_LDA: begin a_nxt = m; r = m; end
      c6502_pkg::OP_LDX: begin x_nxt = m; r = m; end
      c6502_pkg::OP_LDY: begin y_nxt = m; r = m; end
      c6502_pkg::OP_STA: begin wr = 1'b1; wdata = a_r; end
      c6502_pkg::OP_STX: begin wr = 1'b1; wdata = x_r; end
      c6502_pkg::OP_STY: begin wr = 1'b1; wdata = y_r; end
      c6502_pkg::OP_TAX: begin x_nxt = a_r; r = a_r; end
      c6502_pkg::OP_TAY: begin y_nxt = a_r; r = a_r; end
      c6502_pkg::OP_TSX: begin x_nxt = sp_r; r = sp_r; end
      c6502_pkg::OP_TXA: begin a_nxt = x_r; r = x_r; end
      c6502_pkg::OP_TXS: sp_nxt = x_r;
      c6502_pkg::OP_TYA: begin a_nxt = y_r; r = y_r; end
      c6502_pkg::OP_PHA, c6502_pkg::OP_PHP, c6502_pkg::OP_PLA, c6502_pkg::OP_PLP,
      c6502_pkg::OP_RTI, c6502_pkg::OP_RTS, c6502_pkg::OP_BRK,
      c6502_pkg::OP_JSR: stack_op = 1'b1;
      default: ;
    endcase
    case (c6502_pkg::op_t'(it.operation))
      c6502_pkg::OP_ADC, c6502_pkg::OP_SBC, c6502_pkg::OP_AND, c6502_pkg::OP_ORA,
      c6502_pkg::OP_EOR, c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY,
      c6502_pkg::OP_DEC, c6502_pkg::OP_INC, c6502_pkg::OP_DEX, c6502_pkg::OP_DEY,
      c6502_pkg::OP_INX, c6502_pkg::OP_INY, c6502_pkg::OP_LDA, c6502_pkg::OP_LDX,
      c6502_pkg::OP_LDY, c6502_pkg::OP_TAX, c6502_pkg::OP_TAY, c6502_pkg::OP_TSX,
      c6502_pkg::OP_TXA, c6502_pkg::OP_TYA, c6502_pkg::OP_ASL, c6502_pkg::OP_ROL,
      c6502_pkg::OP_LSR, c6502_pkg::OP_ROR: begin
        p_nxt[c6502_pkg::FL_Z] = r == 8'd0;
        p_nxt[c6502_pkg::FL_N] = r[7];
      end
      default: ;
    endcase
    if ((it.operation == c6502_pkg::OP_ASL) || (it.operation == c6502_pkg::OP_ROL) ||
        (it.operation == c6502_pkg::OP_LSR) || (it.operation == c6502_pkg::OP_ROR)) begin
      if (it.on_accumulator) begin
        a_nxt = r;
      end else begin
        wr = 1'b1; wdata = r;
      end
    end
    if (isbr && cond) begin
      pc_nxt = it.address;
      extra = (pc_r[15:8] != it.address[15:8]) ? 2'd2 : 2'd1;
    end
    ret = (it.operation == c6502_pkg::OP_BRK) ? pc_r + 16'd1 : pc_r - 16'd1;
  end

  // stack port: pushes write at sp; pulls read at sp+1
  always_comb begin
    stk_req = '0;
    case (state_r)
      S_RUN: begin
        if (take) begin
          case (c6502_pkg::op_t'(it.operation))
            c6502_pkg::OP_PHA: begin stk_req.wr = 1'b1; stk_req.wdata = a_r; end
            c6502_pkg::OP_PHP: begin stk_req.wr = 1'b1; stk_req.wdata = p_r; end
            c6502_pkg::OP_BRK, c6502_pkg::OP_JSR: begin
              stk_req.wr = 1'b1; stk_req.wdata = ret[15:8];
            end
            c6502_pkg::OP_PLA, c6502_pkg::OP_PLP, c6502_pkg::OP_RTI,
            c6502_pkg::OP_RTS: stk_req.rd = 1'b1;
            default: ;
          endcase
        end
        stk_req.addr = stk_req.rd ? sp_r + 8'd1 : sp_r;
      end
      S_PUSH1: begin stk_req.wr = 1'b1; stk_req.addr = sp_r; stk_req.wdata = b1_r; end
      S_PUSH2: begin stk_req.wr = 1'b1; stk_req.addr = sp_r; stk_req.wdata = b2_r; end
      S_PULL1, S_PULL2: begin stk_req.rd = 1'b1; stk_req.addr = sp_r + 8'd1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      a_r <= '0; x_r <= '0; y_r <= '0; sp_r <= c6502_pkg::SP_RESET; p_r <= '0;
      pc_r <= '0; irq_r <= '0; res_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        irq_r <= cfg_ch.data;
      end
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_RUN: begin
          if (take) begin
            op_r <= it.operation;
            if (stack_op) begin
              case (c6502_pkg::op_t'(it.operation))
                c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
                  sp_r <= sp_r - 8'd1;
                  res_valid_r <= 1'b1;
                  res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, p_r, sp_r - 8'd1, pc_r, 2'd0};
                end
                c6502_pkg::OP_BRK, c6502_pkg::OP_JSR: begin
                  sp_r <= sp_r - 8'd1;
                  b1_r <= ret[7:0];
                  b2_r <= p_r | 8'h10;
                  pc_r <= (it.operation == c6502_pkg::OP_BRK) ? irq_r : it.address;
                  state_r <= S_PUSH1;
                end
                default: begin
                  sp_r <= sp_r + 8'd1;
                  state_r <= S_PULL1;
                end
              endcase
            end else begin
              a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt;
              p_r <= p_nxt; pc_r <= pc_nxt;
              res_valid_r <= 1'b1;
              res_r <= '{wr, wr ? it.address : 16'd0, wdata, a_nxt, x_nxt, y_nxt, p_nxt,
                         sp_nxt, pc_nxt, extra};
            end
          end
        end
        S_PUSH1: begin
          sp_r <= sp_r - 8'd1;
          if (op_r == c6502_pkg::OP_BRK) begin
            state_r <= S_PUSH2;
          end else begin
            state_r <= S_RUN;
            res_valid_r <= 1'b1;
            res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, p_r, sp_r - 8'd1, pc_r, 2'd0};
          end
        end
        S_PUSH2: begin
          sp_r <= sp_r - 8'd1;
          p_r <= p_r | 8'h04;
          state_r <= S_RUN;
          res_valid_r <= 1'b1;
          res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, p_r | 8'h04, sp_r - 8'd1, pc_r, 2'd0};
        end
        S_PULL1: begin
          if (op_r == c6502_pkg::OP_PLA) begin
            a_r <= stk_rdata;
            p_r <= {stk_rdata[7], p_r[6:2], stk_rdata == 8'd0, p_r[0]};
            state_r <= S_RUN;
            res_valid_r <= 1'b1;
            res_r <= '{1'b0, 16'd0, 8'd0, stk_rdata, x_r, y_r,
                       {stk_rdata[7], p_r[6:2], stk_rdata == 8'd0, p_r[0]}, sp_r, pc_r, 2'd0};
          end else if (op_r == c6502_pkg::OP_PLP) begin
            p_r <= stk_rdata;
            state_r <= S_RUN;
            res_valid_r <= 1'b1;
            res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, stk_rdata, sp_r, pc_r, 2'd0};
          end else begin
            sp_r <= sp_r + 8'd1;
            if (op_r == c6502_pkg::OP_RTI) begin
              p_r <= stk_rdata;
            end else begin
              lo_r <= stk_rdata;
            end
            state_r <= S_PULL2;
          end
        end
        S_PULL2: begin
          if (op_r == c6502_pkg::OP_RTI) begin
            lo_r <= stk_rdata;
            sp_r <= sp_r + 8'd1;
            state_r <= S_PULL3;
          end else begin
            pc_r <= {stk_rdata, lo_r} + 16'd1;
            state_r <= S_RUN;
            res_valid_r <= 1'b1;
            res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, p_r, sp_r,
                       {stk_rdata, lo_r} + 16'd1, 2'd0};
          end
        end
        S_PULL3: begin
          pc_r <= {stk_rdata, lo_r};
          state_r <= S_RUN;
          res_valid_r <= 1'b1;
          res_r <= '{1'b0, 16'd0, 8'd0, a_r, x_r, y_r, p_r, sp_r, {stk_rdata, lo_r}, 2'd0};
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_RUN) else $error("ready outside run state");
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_req.wr && stk_req.rd)) else $error("stack read and write together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_ready |=> res_valid_r && $stable(res_r))
    else $error("result dropped");
  a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH1 |=> $past(sp_r) == sp_r + 8'd1) else $error("push sp");
endmodule

### sim/cpu_6502_instruction_execute_tb.sv
// Testbench for the 6502 execute unit: directed table then random instruction streams,
// every result checked against a behavioural model of the register file and stack page.
// Depends on c6502_pkg, the channel interfaces and cpu_6502_instruction_execute.
`timescale 1ns / 1ps
module cpu_6502_instruction_execute_tb;
  import c6502_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    op_t         op;
    logic [7:0]  operand;
    logic [15:0] address;
    logic        on_acc;
    logic        has_exp;
    logic [7:0]  exp_acc;
    logic [7:0]  exp_flags;
  } vec_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  int   sent;
  int   got;
  bit   calm;

  c6502_in_if  in_ch();
  c6502_out_if out_ch();
  c6502_cfg_if cfg_ch();

  cpu_6502_instruction_execute dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  // model state
  logic [7:0]  m_a, m_x, m_y, m_sp, m_p;
  logic [15:0] m_pc, m_irq;
  logic [7:0]  m_stack [256];
  int          depth;  // bytes pushed and not yet pulled
  out_item_t   pending_results [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[FL_Z] = (v == 8'h00);
    q[FL_N] = v[7];
    return q;
  endfunction

  function automatic logic [1:0] take_branch(input logic c, input logic [15:0] dest);
    logic [1:0] e;
    e = 2'd0;
    if (c) begin
      e = (m_pc[15:8] != dest[15:8]) ? 2'd2 : 2'd1;
      m_pc = dest;
    end
    return e;
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    m_stack[m_sp] = v;
    m_sp = m_sp - 8'd1;
    depth++;
  endfunction

  function automatic logic [7:0] pull_byte();
    m_sp = m_sp + 8'd1;
    depth--;
    return m_stack[m_sp];
  endfunction

  function automatic void execute_instruction(input in_item_t it);
    out_item_t  r;
    logic [7:0] m, src, res;
    logic [8:0] sum;
    logic       cin;
    logic [15:0] t;
    r = '0;
    m = it.operand;
    cin = m_p[FL_C];
    case (op_t'(it.operation))
      OP_ADC, OP_SBC: begin
        if (it.operation == OP_SBC) m = ~m;
        sum = {1'b0, m_a} + {1'b0, m} + {8'd0, cin};
        m_p[FL_C] = sum[8];
        m_p[FL_V] = ~(m_a[7] ^ m[7]) & (m_a[7] ^ sum[7]);
        m_a = sum[7:0];
        m_p = nz(m_p, m_a);
      end
      OP_AND: begin m_a = m_a & m; m_p = nz(m_p, m_a); end
      OP_ORA: begin m_a = m_a | m; m_p = nz(m_p, m_a); end
      OP_EOR: begin m_a = m_a ^ m; m_p = nz(m_p, m_a); end
      OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
        src = it.on_accumulator ? m_a : m;
        if (it.operation == OP_ASL || it.operation == OP_ROL) begin
          res = {src[6:0], (it.operation == OP_ROL) & cin};
          m_p[FL_C] = src[7];
        end else begin
          res = {(it.operation == OP_ROR) & cin, src[7:1]};
          m_p[FL_C] = src[0];
        end
        m_p = nz(m_p, res);
        if (it.on_accumulator) m_a = res;
        else begin r.mem_write = 1'b1; r.write_data = res; end
      end
      OP_BCC: r.extra_cycles = take_branch(!m_p[FL_C], it.address);
      OP_BCS: r.extra_cycles = take_branch(m_p[FL_C], it.address);
      OP_BEQ: r.extra_cycles = take_branch(m_p[FL_Z], it.address);
      OP_BNE: r.extra_cycles = take_branch(!m_p[FL_Z], it.address);
      OP_BMI: r.extra_cycles = take_branch(m_p[FL_N], it.address);
      OP_BPL: r.extra_cycles = take_branch(!m_p[FL_N], it.address);
      OP_BVC: r.extra_cycles = take_branch(!m_p[FL_V], it.address);
      OP_BVS: r.extra_cycles = take_branch(m_p[FL_V], it.address);
      OP_BIT: begin
        m_p[FL_Z] = ((m_a & m) == 8'h00);
        m_p[FL_N] = m[7];
        m_p[FL_V] = m[6];
      end
      OP_BRK: begin
        t = m_pc + 16'd1;
        push_byte(t[15:8]);
        push_byte(t[7:0]);
        push_byte(m_p | 8'h10);
        m_p[FL_I] = 1'b1;
        m_pc = m_irq;
      end
      OP_CLC: m_p[FL_C] = 1'b0;
      OP_CLD: m_p[FL_D] = 1'b0;
      OP_CLI: m_p[FL_I] = 1'b0;
      OP_CLV: m_p[FL_V] = 1'b0;
      OP_SEC: m_p[FL_C] = 1'b1;
      OP_SED: m_p[FL_D] = 1'b1;
      OP_SEI: m_p[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        src = (it.operation == OP_CMP) ? m_a : (it.operation == OP_CPX) ? m_x : m_y;
        m_p = nz(m_p, src - m);
        m_p[FL_C] = (src >= m);
      end
      OP_DEC: begin r.mem_write = 1'b1; r.write_data = m - 8'd1; m_p = nz(m_p, r.write_data); end
      OP_INC: begin r.mem_write = 1'b1; r.write_data = m + 8'd1; m_p = nz(m_p, r.write_data); end
      OP_DEX: begin m_x = m_x - 8'd1; m_p = nz(m_p, m_x); end
      OP_DEY: begin m_y = m_y - 8'd1; m_p = nz(m_p, m_y); end
      OP_INX: begin m_x = m_x + 8'd1; m_p = nz(m_p, m_x); end
      OP_INY: begin m_y = m_y + 8'd1; m_p = nz(m_p, m_y); end
      OP_JMP: m_pc = it.address;
      OP_JSR: begin
        t = m_pc - 16'd1;
        push_byte(t[15:8]);
        push_byte(t[7:0]);
        m_pc = it.address;
      end
      OP_LDA: begin m_a = m; m_p = nz(m_p, m); end
      OP_LDX: begin m_x = m; m_p = nz(m_p, m); end
      OP_LDY: begin m_y = m; m_p = nz(m_p, m); end
      OP_PHA: push_byte(m_a);
      OP_PHP: push_byte(m_p);
      OP_PLA: begin m_a = pull_byte(); m_p = nz(m_p, m_a); end
      OP_PLP: m_p = pull_byte();
      OP_RTI: begin
        m_p = pull_byte();
        t[7:0] = pull_byte();
        t[15:8] = pull_byte();
        m_pc = t;
      end
      OP_RTS: begin
        t[7:0] = pull_byte();
        t[15:8] = pull_byte();
        m_pc = t + 16'd1;
      end
      OP_STA: begin r.mem_write = 1'b1; r.write_data = m_a; end
      OP_STX: begin r.mem_write = 1'b1; r.write_data = m_x; end
      OP_STY: begin r.mem_write = 1'b1; r.write_data = m_y; end
      OP_TAX: begin m_x = m_a; m_p = nz(m_p, m_x); end
      OP_TAY: begin m_y = m_a; m_p = nz(m_p, m_y); end
      OP_TSX: begin m_x = m_sp; m_p = nz(m_p, m_x); end
      OP_TXA: begin m_a = m_x; m_p = nz(m_p, m_a); end
      OP_TXS: m_sp = m_x;
      OP_TYA: begin m_a = m_y; m_p = nz(m_p, m_a); end
      default: ;
    endcase
    if (r.mem_write) r.write_address = it.address;
    r.acc_out = m_a;
    r.x_out = m_x;
    r.y_out = m_y;
    r.flags_out = m_p;
    r.sp_out = m_sp;
    r.pc_out = m_pc;
    pending_results.push_back(r);
  endfunction

  // stall cycles: random bursts, none once calm
  task automatic gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_request(input in_item_t it);
    gap();
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    execute_instruction(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_irq_vector(input logic [15:0] v);
    drain();
    cfg_ch.data <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    m_irq = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // consumer with random stall bursts
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    out_item_t e, a;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        got++;
        if (pending_results.size() == 0) begin
          $error("result with none expected");
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (a.mem_write !== e.mem_write) begin
            $error("mem_write exp %0h got %0h", e.mem_write, a.mem_write); errors++; end
          if (a.write_address !== e.write_address) begin
            $error("write_address exp %0h got %0h", e.write_address, a.write_address);
            errors++; end
          if (a.write_data !== e.write_data) begin
            $error("write_data exp %0h got %0h", e.write_data, a.write_data); errors++; end
          if (a.acc_out !== e.acc_out) begin
            $error("acc_out exp %0h got %0h", e.acc_out, a.acc_out); errors++; end
          if (a.x_out !== e.x_out) begin
            $error("x_out exp %0h got %0h", e.x_out, a.x_out); errors++; end
          if (a.y_out !== e.y_out) begin
            $error("y_out exp %0h got %0h", e.y_out, a.y_out); errors++; end
          if (a.flags_out !== e.flags_out) begin
            $error("flags_out exp %0h got %0h", e.flags_out, a.flags_out); errors++; end
          if (a.sp_out !== e.sp_out) begin
            $error("sp_out exp %0h got %0h", e.sp_out, a.sp_out); errors++; end
          if (a.pc_out !== e.pc_out) begin
            $error("pc_out exp %0h got %0h", e.pc_out, a.pc_out); errors++; end
          if (a.extra_cycles !== e.extra_cycles) begin
            $error("extra_cycles exp %0h got %0h", e.extra_cycles, a.extra_cycles);
            errors++; end
        end
      end
    end
  end

  function automatic in_item_t mk(input op_t op, input logic [7:0] m, input logic [15:0] ad,
                                  input logic acc);
    in_item_t it;
    it.operation = op;
    it.operand = m;
    it.address = ad;
    it.on_accumulator = acc;
    return it;
  endfunction

  initial begin
    vec_t       table_rows [$];
    vec_t       v;
    in_item_t   it;
    out_item_t  chk;
    int         k, n, code;
    logic [15:0] vecs [4];

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    errors = 0; sent = 0; got = 0; calm = 0;
    m_a = 0; m_x = 0; m_y = 0; m_sp = SP_RESET; m_p = 0; m_pc = 0; m_irq = 0;
    depth = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // op, operand, address, acc, typed?, A, P
    table_rows = '{
      '{OP_NOP, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h00, 8'h00},
      '{OP_LDA, 8'h00, 16'h0000, 1'b0, 1'b1, 8'h00, 8'h02},
      '{OP_LDA, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 8'h80},
      '{OP_ADC, 8'h01, 16'h0000, 1'b0, 1'b1, 8'h00, 8'h03},
      '{OP_ADC, 8'h7F, 16'h0000, 1'b0, 1'b1, 8'h80, 8'hC0},
      '{OP_SBC, 8'h01, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_ROR, 8'h01, 16'h1234, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_ROL, 8'h80, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00},
      '{OP_BEQ, 8'h00, 16'h0180, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_BNE, 8'h00, 16'h01FF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_JSR, 8'h00, 16'h8000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_PHA, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_PLA, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_RTS, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_BRK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_RTI, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_LDY, 8'h40, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_CPY, 8'h40, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_BIT, 8'hC0, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_EOR, 8'hAA, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_ORA, 8'h55, 16'hABCD, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_TXS, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_ILL, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00},
      '{OP_LDX, 8'hFD, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00},
      '{OP_TXS, 8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00}
    };
    write_irq_vector(16'hFFFF);
    foreach (table_rows[i]) begin
      v = table_rows[i];
      send_request(mk(v.op, v.operand, v.address, v.on_acc));
      chk = pending_results[$];
      if (v.has_exp && (chk.acc_out !== v.exp_acc || chk.flags_out !== v.exp_flags)) begin
        $error("acc_out/flags_out row %0d exp %0h/%0h model %0h/%0h", i, v.exp_acc,
               v.exp_flags, chk.acc_out, chk.flags_out);
        errors++;
      end
    end
    // codes above ILL act as no-ops
    for (k = 57; k < 64; k++) begin
      it = mk(OP_NOP, 8'hFF, 16'hFFFF, 1'b1);
      it.operation = k[5:0];
      send_request(it);
    end

    vecs = '{16'h0000, 16'hFFFF, 16'hA55A, 16'h1234};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) calm = 1;
      write_irq_vector(ph == 3 ? 16'(($urandom())) : vecs[ph]);
      for (n = 0; n < 500; n++) begin
        it = mk(OP_NOP, 8'($urandom()), 16'($urandom()), 1'($urandom()));
        code = $urandom_range(0, 63);
        // pulls only from bytes this run has pushed; keep a little headroom
        if (code == OP_PLA || code == OP_PLP) begin
          if (depth < 1) code = OP_PHA;
        end else if (code == OP_RTS) begin
          if (depth < 2) code = OP_JSR;
        end else if (code == OP_RTI) begin
          if (depth < 3) code = OP_BRK;
        end else if (code == OP_TXS) begin
          code = OP_TSX;
        end
        if ((code == OP_PHA || code == OP_PHP || code == OP_JSR || code == OP_BRK)
            && depth > 200)
          code = OP_RTS;
        if (code == OP_RTS && depth < 2) code = OP_NOP;
        it.operation = code[5:0];
        // occasional nearby branch targets to exercise the same-page case
        if ($urandom_range(0, 1)) it.address = {m_pc[15:8], it.address[7:0]};
        send_request(it);
      end
    end
    drain();
    $display("Ran %0d instructions (%0d results) over four IRQ vector settings,", sent, got);
    $display("including directed edge cases and stack-balanced random streams.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
